[hw/rtl/assert_macros.svh]
// assertion macros for the prediction history rtl, used by tph_back
// expects clk_i and rst_ni in the scope of the module that uses them
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every clock edge outside reset
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// condition that must be followed by another in the next cycle
`define ASSERT_NEXT(label, pre, post, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) else $error(msg);

`endif

[hw/rtl/tph_pkg.sv]
// types and constants of the timestamped prediction history
// no dependencies; imported by every module of the block
package tph_pkg;

  // element counter width and its saturation value
  localparam int unsigned CountW = 5;
  localparam logic [CountW-1:0] CountMax = 5'd31;

  // configuration register indexes
  localparam int unsigned CfgIdxW = 3;
  localparam logic [CfgIdxW-1:0] CFG_SAMPLE_COUNT = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_PREDICTION_SLOT = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_PREDICT_AFTER_MS = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_TOLERANCE_MS = 3'd3;

  // opcodes of an input transaction
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_READ = 1'b1;

  // queue between front and back
  localparam int unsigned QueueDepth = 2;
  localparam int unsigned QueuePtrW = 1;
  localparam int unsigned QueueCntW = 2;

  typedef enum logic [1:0] {
    STATUS_OKAY  = 2'd0,
    STATUS_UNDER = 2'd1,
    STATUS_ERROR = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    KIND_WRITE      = 2'd0,
    KIND_WRITE_LAST = 2'd1,
    KIND_READ       = 2'd2
  } kind_e;

  typedef struct packed {
    kind_e       kind;
    logic [31:0] now_ms;
    logic [31:0] sample_value;
  } item_t;

  typedef struct packed {
    logic [CountW-1:0] sample_count;
    logic [3:0]        prediction_slot;
    logic [15:0]       predict_after_ms;
    logic [15:0]       tolerance_ms;
  } cfg_t;

endpackage

[hw/rtl/tph_front.sv]
// front stage: takes input transactions and classifies them into items
// depends on tph_pkg
module tph_front import tph_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        opcode_i,
  input  logic        last_i,
  input  logic [31:0] now_ms_i,
  input  logic [31:0] sample_value_i,
  output logic        push_valid_o,
  input  logic        push_ready_i,
  output item_t       push_item_o
);

  logic  valid_q;
  item_t item_q;
  item_t item_d;

  assign in_ready_o   = !valid_q || push_ready_i;
  assign push_valid_o = valid_q;
  assign push_item_o  = item_q;

  // classify by opcode and last flag
  always_comb begin
    item_d.now_ms       = now_ms_i;
    item_d.sample_value = sample_value_i;
    priority if (opcode_i == OP_READ) begin
      item_d.kind = KIND_READ;
    end else if (last_i) begin
      item_d.kind = KIND_WRITE_LAST;
    end else begin
      item_d.kind = KIND_WRITE;
    end
  end

  // holding register control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  // holding register payload
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      item_q <= item_d;
    end
  end

endmodule

[hw/rtl/tph_queue.sv]
// two-entry item queue between front and back
// depends on tph_pkg
module tph_queue import tph_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_valid_i,
  output logic  push_ready_o,
  input  item_t push_item_i,
  output logic  pop_valid_o,
  input  logic  pop_ready_i,
  output item_t pop_item_o
);

  item_t                entry_q [QueueDepth];
  logic [QueuePtrW-1:0] wr_ptr_q;
  logic [QueuePtrW-1:0] rd_ptr_q;
  logic [QueueCntW-1:0] count_q;
  logic                 push;
  logic                 pop;

  assign push_ready_o = count_q != QueueCntW'(QueueDepth);
  assign pop_valid_o  = count_q != '0;
  assign pop_item_o   = entry_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  // pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      if (push && !pop) begin
        count_q <= count_q + 1'b1;
      end else if (pop && !push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  // entry storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wr_ptr_q] <= push_item_i;
    end
  end

endmodule

[hw/rtl/tph_back.sv]
// back stage: row store, write commit, newest-first read scan, result register
// depends on tph_pkg and assert_macros.svh
`include "assert_macros.svh"
module tph_back import tph_pkg::*; #(
  parameter int unsigned MAX_ROWS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  cfg_t        cfg_i,
  input  logic        pop_valid_i,
  output logic        pop_ready_o,
  input  item_t       pop_item_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output status_e     out_status_o,
  output logic [31:0] out_value_o
);

  localparam int unsigned RowW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int unsigned AddrW = 2 * RowW;
  localparam int unsigned CmpW = (RowW > CountW) ? RowW : CountW;
  localparam logic [CountW-1:0] RowsCap = (MAX_ROWS > 31) ? CountW'(31) : CountW'(MAX_ROWS);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_FETCH
  } state_e;

  state_e              state_q;
  logic [RowW-1:0]     wr_row_q;
  logic [CountW-1:0]   elem_cnt_q;
  logic [MAX_ROWS-1:0] row_valid_q;
  logic [31:0]         times_mem [MAX_ROWS];
  logic [31:0]         values_mem [MAX_ROWS << RowW];

  logic [CountW-1:0] n_q;
  logic [RowW-1:0]   slot_q;
  logic [15:0]       lo_q;
  logic [16:0]       hi_q;
  logic [31:0]       now_q;
  logic [RowW-1:0]   idx_q;
  logic [CountW-1:0] left_q;
  logic              chk_v_q;
  logic              chk_ok_q;
  logic [RowW-1:0]   chk_idx_q;
  logic [31:0]       time_rd_q;
  logic [31:0]       val_rd_q;
  logic              out_valid_q;
  status_e           out_status_q;
  logic [31:0]       out_value_q;

  logic [CountW-1:0] n_cur;
  logic [RowW-1:0]   n_last;
  logic [RowW-1:0]   n_last_q;
  logic [RowW-1:0]   p_cur;
  logic [RowW-1:0]   p_next;
  logic [RowW-1:0]   idx_start;
  logic [RowW-1:0]   idx_step;
  logic [CountW-1:0] ec_inc;
  logic              ec_in_row;
  logic              slot_bad;
  logic              out_free;
  logic              pop;
  logic              is_write;
  logic              commit;
  logic              val_we;
  logic [AddrW-1:0]  val_waddr;
  logic [AddrW-1:0]  val_raddr;
  logic [31:0]       age;
  logic              hit;
  logic [15:0]       lo_d;
  logic [16:0]       hi_d;

  // rows in use and effective write row
  always_comb begin
    if (cfg_i.sample_count == '0) begin
      n_cur = CountW'(1);
    end else if (cfg_i.sample_count > RowsCap) begin
      n_cur = RowsCap;
    end else begin
      n_cur = cfg_i.sample_count;
    end
  end

  assign n_last    = RowW'(n_cur - 1'b1);
  assign n_last_q  = RowW'(n_q - 1'b1);
  assign p_cur     = (CmpW'(wr_row_q) < CmpW'(n_cur)) ? wr_row_q : '0;
  assign p_next    = (p_cur == n_last) ? '0 : p_cur + 1'b1;
  assign idx_start = (p_cur == '0) ? n_last : p_cur - 1'b1;
  assign idx_step  = (idx_q == '0) ? n_last_q : idx_q - 1'b1;

  // element bookkeeping for writes
  assign ec_in_row = elem_cnt_q < n_cur;
  assign ec_inc    = (elem_cnt_q != CountMax) ? elem_cnt_q + 1'b1 : elem_cnt_q;
  assign slot_bad  = {1'b0, cfg_i.prediction_slot} >= n_cur;

  // handshake with queue and result register
  assign out_free    = !out_valid_q || out_ready_i;
  assign pop_ready_o = (state_q == S_IDLE) && out_free;
  assign pop         = pop_valid_i && pop_ready_o;
  assign is_write    = pop && (pop_item_i.kind != KIND_READ);
  assign commit      = is_write && (pop_item_i.kind == KIND_WRITE_LAST) && (ec_inc == n_cur);
  assign val_we      = is_write && ec_in_row;
  assign val_waddr   = {p_cur, RowW'(elem_cnt_q)};
  assign val_raddr   = {chk_idx_q, slot_q};

  // age window bounds, lower bound clamped at zero
  assign lo_d = (cfg_i.predict_after_ms > cfg_i.tolerance_ms) ?
                cfg_i.predict_after_ms - cfg_i.tolerance_ms : 16'd0;
  assign hi_d = {1'b0, cfg_i.predict_after_ms} + {1'b0, cfg_i.tolerance_ms};

  // age check of the row read in the previous cycle
  assign age = now_q - time_rd_q;
  assign hit = chk_v_q && chk_ok_q && (age >= {16'd0, lo_q}) && (age <= {15'd0, hi_q});

  // commit time store
  always_ff @(posedge clk_i) begin
    if (commit) begin
      times_mem[p_cur] <= pop_item_i.now_ms;
    end
    time_rd_q <= times_mem[idx_q];
  end

  // row value store
  always_ff @(posedge clk_i) begin
    if (val_we) begin
      values_mem[val_waddr] <= pop_item_i.sample_value;
    end
    val_rd_q <= values_mem[val_raddr];
  end

  // sequencer, row state and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      wr_row_q     <= '0;
      elem_cnt_q   <= '0;
      row_valid_q  <= '0;
      n_q          <= '0;
      slot_q       <= '0;
      lo_q         <= '0;
      hi_q         <= '0;
      now_q        <= '0;
      idx_q        <= '0;
      left_q       <= '0;
      chk_v_q      <= 1'b0;
      chk_ok_q     <= 1'b0;
      chk_idx_q    <= '0;
      out_valid_q  <= 1'b0;
      out_status_q <= STATUS_OKAY;
      out_value_q  <= '0;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          if (pop && is_write) begin
            // one word of a row, commit on the last word
            out_valid_q <= 1'b1;
            out_value_q <= '0;
            if (pop_item_i.kind == KIND_WRITE_LAST) begin
              elem_cnt_q <= '0;
              if (commit) begin
                row_valid_q[p_cur] <= 1'b1;
                wr_row_q           <= p_next;
                out_status_q       <= STATUS_OKAY;
              end else begin
                if (elem_cnt_q == '0) begin
                  row_valid_q[p_cur] <= 1'b0;
                end
                out_status_q <= STATUS_ERROR;
              end
            end else begin
              if (elem_cnt_q == '0) begin
                row_valid_q[p_cur] <= 1'b0;
              end
              elem_cnt_q   <= ec_inc;
              out_status_q <= STATUS_OKAY;
            end
          end else if (pop && slot_bad) begin
            out_valid_q  <= 1'b1;
            out_status_q <= STATUS_ERROR;
            out_value_q  <= '0;
          end else if (pop) begin
            // start scan at the newest row, any pending result is taken now
            out_valid_q <= 1'b0;
            n_q         <= n_cur;
            slot_q      <= RowW'(cfg_i.prediction_slot);
            lo_q        <= lo_d;
            hi_q        <= hi_d;
            now_q       <= pop_item_i.now_ms;
            idx_q       <= idx_start;
            left_q      <= n_cur;
            chk_v_q     <= 1'b0;
            state_q     <= S_SCAN;
          end else if (out_ready_i) begin
            out_valid_q <= 1'b0;
          end
        end
        S_SCAN: begin
          // issue one row per cycle, check it in the next cycle
          if (hit) begin
            chk_v_q <= 1'b0;
            state_q <= S_FETCH;
          end else if (left_q != '0) begin
            chk_v_q   <= 1'b1;
            chk_ok_q  <= row_valid_q[idx_q];
            chk_idx_q <= idx_q;
            idx_q     <= idx_step;
            left_q    <= left_q - 1'b1;
          end else if (chk_v_q) begin
            chk_v_q <= 1'b0;
          end else begin
            out_valid_q  <= 1'b1;
            out_status_q <= STATUS_UNDER;
            out_value_q  <= '0;
            state_q      <= S_IDLE;
          end
        end
        S_FETCH: begin
          out_valid_q  <= 1'b1;
          out_status_q <= STATUS_OKAY;
          out_value_q  <= val_rd_q;
          state_q      <= S_IDLE;
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_status_o = out_status_q;
  assign out_value_o  = out_value_q;

  // result register is empty for the whole scan
  `ASSERT_CLK(a_out_empty_in_scan, (state_q == S_SCAN || state_q == S_FETCH) |-> !out_valid_q, "result pending during scan")
  // scan never issues more rows than are in use
  `ASSERT_CLK(a_left_bounded, (state_q == S_SCAN) |-> (left_q <= n_q), "scan count beyond rows in use")
  // a matching row is always followed by its value fetch
  `ASSERT_NEXT(a_hit_then_fetch, hit, state_q == S_FETCH, "match not followed by fetch")

endmodule

[hw/rtl/timestamped_prediction_history.sv]
// top level of the timestamped prediction history: config registers and stage wiring
// depends on tph_pkg, tph_front, tph_queue and tph_back
//
//   channel   direction  handshake                    contents
//   cfg       in         cfg_valid_i / cfg_ready_o    cfg_index_i, cfg_data_i
//   s_axis    in         s_axis_tvalid / tready       now_ms, sample_value, opcode, last
//   m_axis    out        m_axis_tvalid / tready       status, value_out
//
// a write transaction is handled in the idle state of the back stage without leaving it
// a read scans the rows in use newest first, one row time read per cycle through the
// commit time memory, each followed by its age check, and reads the value memory on a match
// front register and queue absorb input stalls
// the result register frees the back stage as soon as the sink takes a result
// reset clears valid bits and pointers at once; no clearing pass is needed
module timestamped_prediction_history import tph_pkg::*; #(
  parameter int unsigned MAX_ROWS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [15:0]        cfg_data_i,
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  input  logic [63:0]        s_axis_tdata,  // now_ms [31:0], sample_value [63:32]
  input  logic               s_axis_tuser,  // opcode
  input  logic               s_axis_tlast,
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  output logic [39:0]        m_axis_tdata   // status [1:0], value_out [33:2], zero [39:34]
);

  cfg_t        cfg_q;
  logic        push_valid;
  logic        push_ready;
  item_t       push_item;
  logic        pop_valid;
  logic        pop_ready;
  item_t       pop_item;
  status_e     out_status;
  logic [31:0] out_value;

  assign cfg_ready_o = 1'b1;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.sample_count     <= CountW'(16);
      cfg_q.prediction_slot  <= '0;
      cfg_q.predict_after_ms <= '0;
      cfg_q.tolerance_ms     <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CFG_SAMPLE_COUNT:     cfg_q.sample_count     <= cfg_data_i[CountW-1:0];
        CFG_PREDICTION_SLOT:  cfg_q.prediction_slot  <= cfg_data_i[3:0];
        CFG_PREDICT_AFTER_MS: cfg_q.predict_after_ms <= cfg_data_i;
        CFG_TOLERANCE_MS:     cfg_q.tolerance_ms     <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  tph_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (s_axis_tvalid),
    .in_ready_o     (s_axis_tready),
    .opcode_i       (s_axis_tuser),
    .last_i         (s_axis_tlast),
    .now_ms_i       (s_axis_tdata[31:0]),
    .sample_value_i (s_axis_tdata[63:32]),
    .push_valid_o   (push_valid),
    .push_ready_i   (push_ready),
    .push_item_o    (push_item)
  );

  tph_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_item_i  (push_item),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_item_o   (pop_item)
  );

  tph_back #(
    .MAX_ROWS (MAX_ROWS)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .pop_valid_i  (pop_valid),
    .pop_ready_o  (pop_ready),
    .pop_item_i   (pop_item),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_status_o (out_status),
    .out_value_o  (out_value)
  );

  assign m_axis_tdata = {6'd0, out_value, out_status};

endmodule

[tb/timestamped_prediction_history_tb.sv]
// self-checking testbench of the timestamped prediction history
// holds its own history predictor and drives directed and random streams
// depends on tph_pkg and the timestamped_prediction_history top level
module timestamped_prediction_history_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import tph_pkg::*;

  localparam int unsigned HistRows = 16;
  localparam int unsigned CycleLimit = 1000000;
  localparam int unsigned SettleCycles = 32;

  typedef struct {
    status_e     status;
    logic [31:0] value;
  } prediction_t;

  // clock, reset and block ports
  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               cfg_valid_i = 1'b0;
  logic               cfg_ready_o;
  logic [CfgIdxW-1:0] cfg_index_i = '0;
  logic [15:0]        cfg_data_i = '0;
  logic               s_axis_tvalid = 1'b0;
  logic               s_axis_tready;
  logic [63:0]        s_axis_tdata = '0;  // now_ms [31:0], sample_value [63:32]
  logic               s_axis_tuser = 1'b0;  // opcode
  logic               s_axis_tlast = 1'b0;
  logic               m_axis_tvalid;
  logic               m_axis_tready = 1'b0;
  logic [39:0]        m_axis_tdata;  // status [1:0], value_out [33:2], zero [39:34]

  // shadow copy of the configuration registers
  logic [4:0]  shadow_count = 5'd16;
  logic [3:0]  shadow_slot = '0;
  logic [15:0] shadow_after = '0;
  logic [15:0] shadow_tol = '0;

  // predicted history state
  logic [31:0] hist_times [HistRows];
  bit          hist_valid [HistRows];
  logic [31:0] hist_values [HistRows][HistRows];
  bit          hist_written [HistRows][HistRows];
  int          hist_wr = 0;
  logic [4:0]  hist_count = '0;

  prediction_t predicted_results[$];
  prediction_t oldest;
  int          mismatches = 0;
  int          items_sent = 0;
  int          cycle_count = 0;
  int          stall_left = 0;
  bit          steady_flow = 1'b0;
  logic [31:0] ms_clock = '0;

  timestamped_prediction_history #(
    .MAX_ROWS(HistRows)
  ) u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #2 clk_i = ~clk_i;

  // run limit
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // rows in use, clamped to the ring size
  function automatic int rows_active();
    int n;
    n = shadow_count;
    if (n < 1) n = 1;
    if (n > HistRows) n = HistRows;
    return n;
  endfunction

  // newest-to-oldest search for a row whose age falls in the window
  function automatic void scan_history(input logic [31:0] now, output status_e st,
                                       output logic [31:0] val, output bit hole);
    int                n;
    int                p;
    int                idx;
    logic [31:0]       age32;
    longint unsigned   age;
    longint unsigned   lo;
    longint unsigned   hi;
    n = rows_active();
    p = (hist_wr < n) ? hist_wr : 0;
    st = STATUS_UNDER;
    val = '0;
    hole = 1'b0;
    if (shadow_slot >= n) begin
      st = STATUS_ERROR;
      return;
    end
    lo = (shadow_after > shadow_tol) ? longint'(shadow_after - shadow_tol) : 0;
    hi = longint'(shadow_after) + longint'(shadow_tol);
    for (int k = 0; k < n; k++) begin
      idx = (p + n - 1 - k) % n;
      if (!hist_valid[idx]) continue;
      age32 = now - hist_times[idx];
      age = age32;
      if (age >= lo && age <= hi) begin
        st = STATUS_OKAY;
        val = hist_values[idx][shadow_slot];
        hole = !hist_written[idx][shadow_slot];
        return;
      end
    end
  endfunction

  // one word into the row under construction, commit on the last word
  function automatic status_e commit_word(input logic [31:0] now, input logic [31:0] word,
                                          input logic last);
    int      n;
    int      p;
    status_e st;
    n = rows_active();
    p = (hist_wr < n) ? hist_wr : 0;
    st = STATUS_OKAY;
    if (hist_count == 0) hist_valid[p] = 1'b0;
    if (hist_count < n) begin
      hist_values[p][hist_count] = word;
      hist_written[p][hist_count] = 1'b1;
    end
    if (hist_count < CountMax) hist_count++;
    if (last) begin
      if (hist_count == n) begin
        hist_times[p] = now;
        hist_valid[p] = 1'b1;
        hist_wr = (p + 1) % n;
      end else begin
        st = STATUS_ERROR;
      end
      hist_count = '0;
    end
    return st;
  endfunction

  // mostly short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (steady_flow || r < 70) return 0;
    if (r < 94) return $urandom_range(1, 3);
    return $urandom_range(4, 30);
  endfunction

  // time step between transactions, with rare jumps across the wrap
  function automatic logic [31:0] step_ms();
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) return '0;
    if (r < 97) return $urandom_range(1, 20);
    if (r < 99) return $urandom_range(100, 70000);
    return $urandom();
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] want,
                                 input logic [31:0] got);
    $display("mismatch on %s: expected %h, got %h (cycle %0d)", what, want, got,
             cycle_count);
    mismatches++;
  endtask

  // one input transaction; reads that would hit a never-written word are dropped
  task automatic send_item(input logic op, input logic [31:0] now, input logic [31:0] word,
                           input logic last);
    prediction_t pr;
    bit          hole;
    int          gap;
    hole = 1'b0;
    if (op == OP_READ) begin
      scan_history(now, pr.status, pr.value, hole);
      if (hole) return;
    end
    gap = pick_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {word, now};
    s_axis_tuser <= op;
    s_axis_tlast <= last;
    do @(posedge clk_i); while (!s_axis_tready);
    if (op == OP_WRITE) begin
      pr.status = commit_word(now, word, last);
      pr.value = '0;
    end
    predicted_results.push_back(pr);
    items_sent++;
    @(negedge clk_i);
  endtask

  // stop sending and wait for every predicted result
  task automatic drain_results(input int settle);
    s_axis_tvalid <= 1'b0;
    while (predicted_results.size() != 0) @(negedge clk_i);
    repeat (settle) @(negedge clk_i);
  endtask

  // register write, only once the block is idle
  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [15:0] data);
    drain_results(SettleCycles);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      CFG_SAMPLE_COUNT:     shadow_count = data[4:0];
      CFG_PREDICTION_SLOT:  shadow_slot = data[3:0];
      CFG_PREDICT_AFTER_MS: shadow_after = data;
      CFG_TOLERANCE_MS:     shadow_tol = data;
      default: ;
    endcase
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // random mix of well-formed rows, broken rows and reads
  task automatic run_traffic(input int num_items);
    int r;
    int n;
    int len;
    int target;
    target = items_sent + num_items;
    while (items_sent < target) begin
      r = $urandom_range(0, 99);
      n = rows_active();
      if (r < 25) begin
        ms_clock += step_ms();
        send_item(OP_READ, ms_clock, $urandom(), 1'($urandom_range(0, 1)));
      end else if (r < 85) begin
        for (int i = 0; i < n; i++) begin
          ms_clock += step_ms();
          send_item(OP_WRITE, ms_clock, $urandom(), i == n - 1);
          if ($urandom_range(0, 19) == 0) send_item(OP_READ, ms_clock, $urandom(), 1'b0);
        end
      end else begin
        len = $urandom_range(1, n + 3);
        for (int i = 0; i < len; i++) begin
          ms_clock += step_ms();
          send_item(OP_WRITE, ms_clock, $urandom(),
                    (i == len - 1) && ($urandom_range(0, 3) != 0));
        end
      end
    end
  endtask

  // sink side stalls
  always @(negedge clk_i) begin
    if (stall_left > 0) begin
      m_axis_tready <= 1'b0;
      stall_left--;
    end else begin
      m_axis_tready <= 1'b1;
      if (!steady_flow && $urandom_range(0, 99) < 20)
        stall_left = ($urandom_range(0, 99) < 80) ? $urandom_range(1, 3)
                                                  : $urandom_range(4, 40);
    end
  end

  // result checker
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (predicted_results.size() == 0) begin
        report_mismatch("unexpected result", '0, m_axis_tdata[33:2]);
      end else begin
        oldest = predicted_results.pop_front();
        if (m_axis_tdata[1:0] != oldest.status)
          report_mismatch("status", 32'(oldest.status), 32'(m_axis_tdata[1:0]));
        if (m_axis_tdata[33:2] != oldest.value)
          report_mismatch("value_out", oldest.value, m_axis_tdata[33:2]);
      end
    end
  end

  // edges of time, window and row handling with a ring of two rows of two words
  task automatic test_directed_cases();
    write_reg(CFG_SAMPLE_COUNT, 16'd2);
    // empty history
    send_item(OP_READ, 32'h0, $urandom(), 1'b0);
    send_item(OP_WRITE, 32'hFFFF_FFF0, 32'h8000_0000, 1'b0);
    send_item(OP_WRITE, 32'hFFFF_FFF0, 32'h7FFF_FFFF, 1'b1);
    send_item(OP_READ, 32'hFFFF_FFF0, $urandom(), 1'b1);
    // age across the time wrap, outside a zero window
    send_item(OP_READ, 32'h0000_0005, $urandom(), 1'b0);
    // short row, then overlong row
    send_item(OP_WRITE, 32'h1, 32'h0, 1'b1);
    send_item(OP_WRITE, 32'h2, 32'h1234_5678, 1'b0);
    send_item(OP_WRITE, 32'h3, 32'hA5A5_A5A5, 1'b0);
    send_item(OP_WRITE, 32'h4, 32'h5A5A_5A5A, 1'b1);
    send_item(OP_WRITE, 32'h10, 32'h0, 1'b0);
    send_item(OP_WRITE, 32'h10, 32'hFFFF_FFFF, 1'b1);
    // narrow window picks the older row first, then the newer
    write_reg(CFG_PREDICTION_SLOT, 16'd1);
    write_reg(CFG_PREDICT_AFTER_MS, 16'h45);
    write_reg(CFG_TOLERANCE_MS, 16'h8);
    send_item(OP_READ, 32'h37, $urandom(), 1'b0);
    send_item(OP_READ, 32'h55, $urandom(), 1'b0);
    // tolerance above the target clamps the low bound at zero
    write_reg(CFG_PREDICT_AFTER_MS, 16'h4);
    write_reg(CFG_TOLERANCE_MS, 16'hFFFF);
    send_item(OP_READ, 32'h20, $urandom(), 1'b0);
    // slot beyond the rows in use
    write_reg(CFG_PREDICTION_SLOT, 16'd2);
    send_item(OP_READ, 32'h20, $urandom(), 1'b0);
    // widest window, on and just past its upper bound
    write_reg(CFG_PREDICTION_SLOT, 16'd0);
    write_reg(CFG_PREDICT_AFTER_MS, 16'hFFFF);
    send_item(OP_READ, 32'h0002_000E, $urandom(), 1'b0);
    send_item(OP_READ, 32'h0002_000F, $urandom(), 1'b0);
    // write pointer left beyond a count of zero, which acts as one
    send_item(OP_WRITE, 32'h60, $urandom(), 1'b0);
    send_item(OP_WRITE, 32'h60, $urandom(), 1'b1);
    write_reg(CFG_SAMPLE_COUNT, 16'd0);
    send_item(OP_WRITE, 32'h70, $urandom(), 1'b1);
    send_item(OP_READ, 32'h80, $urandom(), 1'b0);
    // count raised above the ring size, then cut to one in the middle of a row
    write_reg(CFG_SAMPLE_COUNT, 16'd31);
    send_item(OP_WRITE, 32'h90, $urandom(), 1'b0);
    write_reg(CFG_SAMPLE_COUNT, 16'd1);
    send_item(OP_WRITE, 32'h91, $urandom(), 1'b1);
  endtask

  // phases of random traffic under changing settings
  task automatic test_random_traffic();
    int n;
    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: write_reg(CFG_SAMPLE_COUNT, 16'd1);
        1: write_reg(CFG_SAMPLE_COUNT, 16'd2);
        2: write_reg(CFG_SAMPLE_COUNT, 16'd16);
        3: write_reg(CFG_SAMPLE_COUNT, 16'd31);
        4: write_reg(CFG_SAMPLE_COUNT, 16'd0);
        5: write_reg(CFG_SAMPLE_COUNT, 16'd16);
        default: write_reg(CFG_SAMPLE_COUNT, 16'($urandom_range(1, 16)));
      endcase
      n = rows_active();
      if ($urandom_range(0, 9) == 0) write_reg(CFG_PREDICTION_SLOT, 16'($urandom_range(0, 15)));
      else write_reg(CFG_PREDICTION_SLOT, 16'($urandom_range(0, n - 1)));
      case (ph)
        5: begin
          write_reg(CFG_PREDICT_AFTER_MS, 16'hFFFF);
          write_reg(CFG_TOLERANCE_MS, 16'hFFFF);
        end
        6: begin
          write_reg(CFG_PREDICT_AFTER_MS, 16'h0);
          write_reg(CFG_TOLERANCE_MS, 16'h0);
        end
        7: begin
          write_reg(CFG_PREDICT_AFTER_MS, 16'h0);
          write_reg(CFG_TOLERANCE_MS, 16'hFFFF);
        end
        default: begin
          write_reg(CFG_PREDICT_AFTER_MS, 16'($urandom_range(0, 10 * n * n + 20)));
          write_reg(CFG_TOLERANCE_MS, 16'($urandom_range(0, 5 * n + 10)));
        end
      endcase
      // one phase runs without any gaps, one starts just before the time wrap
      steady_flow = (ph == 2);
      if (ph == 3) ms_clock = 32'hFFFF_F000;
      run_traffic(240);
      drain_results(0);
      steady_flow = 1'b0;
    end
  endtask

  // bursts with the sender holding until every result is back
  task automatic test_drain_pause();
    write_reg(CFG_SAMPLE_COUNT, 16'd4);
    write_reg(CFG_PREDICTION_SLOT, 16'd3);
    write_reg(CFG_PREDICT_AFTER_MS, 16'd60);
    write_reg(CFG_TOLERANCE_MS, 16'd40);
    for (int b = 0; b < 5; b++) begin
      run_traffic(40);
      drain_results(0);
    end
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    test_directed_cases();
    test_random_traffic();
    test_drain_pause();
    drain_results(SettleCycles);
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
